>>> hw/rtl/tpe_pkg.sv
// Shared types, codes and reset constants for the tape pulse encoder.
`timescale 1ns / 1ps
`default_nettype none

package tpe_pkg;

    // Sizes
    localparam int TAPE_DEPTH_DEF = 65536;
    localparam int ADDR_W         = 16;
    localparam int DATA_W         = 8;
    localparam int ENTRY_W        = 10;
    localparam int HALF_W         = 24;
    localparam int REP_W          = 14;
    localparam int LEN_W          = 16;
    localparam int GAP_W          = 23;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 23;

    // Input operation codes
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_REWIND = 2'd2,
        FUNC_PLAY   = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PILOT_HALF   = 3'd0,
        REG_PILOT_HEADER = 3'd1,
        REG_PILOT_DATA   = 3'd2,
        REG_SYNC_FIRST   = 3'd3,
        REG_SYNC_SECOND  = 3'd4,
        REG_ZERO_HALF    = 3'd5,
        REG_ONE_HALF     = 3'd6,
        REG_GAP_TICKS    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0] pilot_half;
        logic [REP_W-1:0] pilot_count_header;
        logic [REP_W-1:0] pilot_count_data;
        logic [LEN_W-1:0] sync_first_half;
        logic [LEN_W-1:0] sync_second_half;
        logic [LEN_W-1:0] zero_bit_half;
        logic [LEN_W-1:0] one_bit_half;
        logic [GAP_W-1:0] gap_ticks;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        pilot_half:         16'd2168,
        pilot_count_header: 14'd8064,
        pilot_count_data:   14'd3224,
        sync_first_half:    16'd667,
        sync_second_half:   16'd735,
        zero_bit_half:      16'd855,
        one_bit_half:       16'd1710,
        gap_ticks:          23'd3500000
    };

    localparam logic [HALF_W-1:0] HALF_RST = 24'd1;
    localparam logic [REP_W-1:0]  REP_RST  = 14'd1;

    // One stored tape byte with its end marks
    typedef struct packed {
        logic              tape_end;
        logic              block_end;
        logic [DATA_W-1:0] data;
    } entry_t;

    // Input transaction
    typedef struct packed {
        func_t             func;
        logic              ear_in;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic              block_end;
        logic              tape_end;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic ear_out;
        logic playing;
        logic ended;
    } out_t;

    // Decoded command handed from front to back
    typedef struct packed {
        func_t             op;
        logic              ear_in;
        logic [ADDR_W-1:0] address;
        entry_t            entry;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

endpackage

`default_nettype wire

>>> hw/rtl/tpe_ram.sv
// Generic RAM: one write port, two registered read ports (read-old on collision).
`timescale 1ns / 1ps
`default_nettype none

module tpe_ram #(
    parameter int WIDTH = tpe_pkg::ENTRY_W,
    parameter int DEPTH = tpe_pkg::TAPE_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Storage and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tpe_front.sv
// Front end: accepts input transactions, decodes them and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module tpe_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire tpe_pkg::in_t       item,
    output tpe_pkg::cmd_slot_t      slot,
    input  wire logic               take
);

    tpe_pkg::cmd_t q_reg [2];
    logic          wp_reg;
    logic          wp_next;
    logic          rp_reg;
    logic          rp_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic          push_acc;
    tpe_pkg::cmd_t dec;

    // Decode the input transaction into a command
    always_comb
    begin
        dec.op              = item.func;
        dec.ear_in          = item.ear_in;
        dec.address         = item.address;
        dec.entry.tape_end  = item.tape_end;
        dec.entry.block_end = item.block_end;
        dec.entry.data      = item.data;
    end

    // Queue pointers
    assign full     = (cnt_reg == 2'd2);
    assign push_acc = push && !full;

    always_comb
    begin
        wp_next  = push_acc ? ~wp_reg : wp_reg;
        rp_next  = take ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push_acc} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            q_reg[wp_reg] <= dec;
        end
    end

    assign slot.valid = (cnt_reg != 2'd0);
    assign slot.cmd   = q_reg[rp_reg];

`ifndef SYNTHESIS
    a_take_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (cnt_reg != 2'd0))
        else $error("command taken from empty queue");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/tpe_back.sv
// Back end: tape sequencer, tape byte store and result queue.
`timescale 1ns / 1ps
`default_nettype none

module tpe_back #(
    parameter int TAPE_DEPTH = tpe_pkg::TAPE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tpe_pkg::cmd_slot_t               slot,
    output logic                                  take,
    input  wire logic                             pop,
    output logic                                  empty,
    output tpe_pkg::out_t                         result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tpe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(TAPE_DEPTH);

    typedef enum logic [1:0] {
        STG_PILOT = 2'd0,
        STG_SYNC1 = 2'd1,
        STG_SYNC2 = 2'd2,
        STG_DATA  = 2'd3
    } stage_t;

    // Configuration
    tpe_pkg::cfg_t cfg_reg;
    tpe_pkg::cfg_t cfg_next;

    // Sequencer state
    logic [AW-1:0]               rd_ptr_reg,   rd_ptr_next;
    logic                        kind_reg,     kind_next;
    stage_t                      stage_reg,    stage_next;
    logic [tpe_pkg::HALF_W-1:0]  half_reg,     half_next;
    logic [tpe_pkg::REP_W-1:0]   rep_reg,      rep_next;
    logic [tpe_pkg::HALF_W-1:0]  len_reg,      len_next;
    logic [tpe_pkg::DATA_W-1:0]  shift_reg,    shift_next;
    logic [3:0]                  bit_cnt_reg,  bit_cnt_next;
    logic [1:0]                  flags_reg,    flags_next;
    logic                        wave_reg,     wave_next;
    logic                        play_reg,     play_next;
    logic                        end_reg,      end_next;

    // Store access
    logic                        ram_we;
    logic [AW-1:0]               wr_addr;
    logic [tpe_pkg::ENTRY_W-1:0] ram_a;
    logic [tpe_pkg::ENTRY_W-1:0] ram_b;
    logic                        byp_a_reg,    byp_a_next;
    logic                        byp_b_reg,    byp_b_next;
    tpe_pkg::entry_t             byp_data_reg;
    tpe_pkg::entry_t             ent_a;
    tpe_pkg::entry_t             ent_b;

    // Step temporaries
    logic                        fire;
    logic                        np;
    logic                        rewind;
    stage_t                      stage_cur;
    tpe_pkg::entry_t             first;
    logic [2:0]                  bc;
    logic [tpe_pkg::DATA_W-1:0]  sb;
    logic                        ld_en;
    logic [tpe_pkg::HALF_W-1:0]  ld_len;
    logic [tpe_pkg::REP_W-1:0]   ld_rep;
    logic                        ear;
    tpe_pkg::out_t               res;

    // Result queue
    tpe_pkg::out_t               res_q_reg [2];
    logic                        res_wp_reg,   res_wp_next;
    logic                        res_rp_reg,   res_rp_next;
    logic [1:0]                  res_cnt_reg,  res_cnt_next;
    logic                        pop_acc;
    logic                        room;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign pop_acc   = pop && (res_cnt_reg != 2'd0);
    assign room      = (res_cnt_reg != 2'd2) || pop_acc;
    assign fire      = slot.valid && room;
    assign take      = fire;
    assign empty     = (res_cnt_reg == 2'd0);
    assign result    = res_q_reg[res_rp_reg];

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (tpe_pkg::cfg_idx_t'(cfg_index))
                tpe_pkg::REG_PILOT_HALF:
                    cfg_next.pilot_half = cfg_data[tpe_pkg::LEN_W-1:0];
                tpe_pkg::REG_PILOT_HEADER:
                    cfg_next.pilot_count_header = cfg_data[tpe_pkg::REP_W-1:0];
                tpe_pkg::REG_PILOT_DATA:
                    cfg_next.pilot_count_data = cfg_data[tpe_pkg::REP_W-1:0];
                tpe_pkg::REG_SYNC_FIRST:
                    cfg_next.sync_first_half = cfg_data[tpe_pkg::LEN_W-1:0];
                tpe_pkg::REG_SYNC_SECOND:
                    cfg_next.sync_second_half = cfg_data[tpe_pkg::LEN_W-1:0];
                tpe_pkg::REG_ZERO_HALF:
                    cfg_next.zero_bit_half = cfg_data[tpe_pkg::LEN_W-1:0];
                tpe_pkg::REG_ONE_HALF:
                    cfg_next.one_bit_half = cfg_data[tpe_pkg::LEN_W-1:0];
                tpe_pkg::REG_GAP_TICKS:
                    cfg_next.gap_ticks = cfg_data[tpe_pkg::GAP_W-1:0];
            endcase
        end
    end

    // Store read data, with bypass of a write that hit the address being read
    assign ent_a = byp_a_reg ? byp_data_reg : tpe_pkg::entry_t'(ram_a);
    assign ent_b = byp_b_reg ? byp_data_reg : tpe_pkg::entry_t'(ram_b);
    assign wr_addr = AW'(slot.cmd.address);

    // One command step
    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        kind_next    = kind_reg;
        stage_next   = stage_reg;
        half_next    = half_reg;
        rep_next     = rep_reg;
        len_next     = len_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        flags_next   = flags_reg;
        wave_next    = wave_reg;
        play_next    = play_reg;
        end_next     = end_reg;
        ram_we       = 1'b0;
        np           = 1'b0;
        rewind       = 1'b0;
        ld_en        = 1'b0;
        ld_len       = len_reg;
        ld_rep       = rep_reg;
        bc           = bit_cnt_reg[2:0];
        sb           = shift_reg;

        // Operation
        if (fire)
        begin
            unique case (slot.cmd.op)
                tpe_pkg::FUNC_TICK:
                begin
                    if (play_reg)
                    begin
                        if (half_reg == '0)
                        begin
                            wave_next = ~wave_reg;
                            half_next = len_reg;
                            rep_next  = rep_reg - tpe_pkg::REP_W'(1);
                            np        = (rep_reg == tpe_pkg::REP_W'(1));
                        end
                        else
                        begin
                            half_next = half_reg - tpe_pkg::HALF_W'(1);
                        end
                    end
                end
                tpe_pkg::FUNC_WRITE:
                begin
                    ram_we = 1'b1;
                end
                tpe_pkg::FUNC_REWIND:
                begin
                    np     = 1'b1;
                    rewind = 1'b1;
                end
                tpe_pkg::FUNC_PLAY:
                begin
                    if (!end_reg)
                    begin
                        play_next = ~play_reg;
                    end
                end
            endcase
        end

        // Pulse sequencing
        stage_cur = rewind ? STG_PILOT : stage_reg;
        first     = rewind ? ent_b : ent_a;
        if (np)
        begin
            unique case (stage_cur)
                STG_PILOT:
                begin
                    kind_next  = (first.data != '0);
                    ld_en      = 1'b1;
                    ld_len     = tpe_pkg::HALF_W'(cfg_reg.pilot_half);
                    ld_rep     = kind_next ? cfg_reg.pilot_count_data
                                           : cfg_reg.pilot_count_header;
                    wave_next  = 1'b0;
                    stage_next = STG_SYNC1;
                end
                STG_SYNC1:
                begin
                    ld_en      = 1'b1;
                    ld_len     = tpe_pkg::HALF_W'(cfg_reg.sync_first_half);
                    ld_rep     = tpe_pkg::REP_W'(1);
                    stage_next = STG_SYNC2;
                end
                STG_SYNC2:
                begin
                    ld_en        = 1'b1;
                    ld_len       = tpe_pkg::HALF_W'(cfg_reg.sync_second_half);
                    ld_rep       = tpe_pkg::REP_W'(1);
                    stage_next   = STG_DATA;
                    bit_cnt_next = 4'd0;
                end
                STG_DATA:
                begin
                    if (!bit_cnt_reg[3] || (flags_reg == 2'b00))
                    begin
                        // next data bit, fetching a new byte every eight bits
                        if (bc == 3'd0)
                        begin
                            sb          = ent_a.data;
                            flags_next  = {ent_a.tape_end, ent_a.block_end};
                            rd_ptr_next = rd_ptr_reg + AW'(1);
                        end
                        ld_en        = 1'b1;
                        ld_len       = sb[7] ? tpe_pkg::HALF_W'(cfg_reg.one_bit_half)
                                             : tpe_pkg::HALF_W'(cfg_reg.zero_bit_half);
                        ld_rep       = tpe_pkg::REP_W'(2);
                        shift_next   = {sb[6:0], 1'b0};
                        bit_cnt_next = {1'b0, bc} + 4'd1;
                    end
                    else if (flags_reg[1])
                    begin
                        // last block of tape done
                        play_next = 1'b0;
                        end_next  = 1'b1;
                    end
                    else
                    begin
                        // inter-block gap, doubled after a data block
                        ld_en      = 1'b1;
                        ld_len     = kind_reg ? {cfg_reg.gap_ticks, 1'b0}
                                              : {1'b0, cfg_reg.gap_ticks};
                        ld_rep     = tpe_pkg::REP_W'(1);
                        stage_next = STG_PILOT;
                    end
                end
            endcase
        end

        if (ld_en)
        begin
            len_next  = ld_len;
            half_next = ld_len;
            rep_next  = ld_rep;
        end

        if (rewind)
        begin
            rd_ptr_next = '0;
            end_next    = 1'b0;
            play_next   = 1'b0;
        end

        // Result
        if ((slot.cmd.op == tpe_pkg::FUNC_TICK) ? play_reg : play_next)
        begin
            ear = wave_next;
        end
        else
        begin
            ear = slot.cmd.ear_in;
        end
        res.ear_out = ear;
        res.playing = play_next;
        res.ended   = end_next;

        // Bypass flags for the store read issued at this edge
        byp_a_next = ram_we && (wr_addr == rd_ptr_next);
        byp_b_next = ram_we && (wr_addr == '0);
    end

    // Result queue pointers
    always_comb
    begin
        res_wp_next  = fire ? ~res_wp_reg : res_wp_reg;
        res_rp_next  = pop_acc ? ~res_rp_reg : res_rp_reg;
        res_cnt_next = res_cnt_reg + {1'b0, fire} - {1'b0, pop_acc};
    end

    // Tape store
    tpe_ram #(
        .WIDTH (tpe_pkg::ENTRY_W),
        .DEPTH (TAPE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (wr_addr),
        .wdata   (slot.cmd.entry),
        .raddr_a (rd_ptr_next),
        .rdata_a (ram_a),
        .raddr_b ('0),
        .rdata_b (ram_b)
    );

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= tpe_pkg::CFG_RST;
            rd_ptr_reg  <= '0;
            kind_reg    <= 1'b0;
            stage_reg   <= STG_PILOT;
            half_reg    <= tpe_pkg::HALF_RST;
            rep_reg     <= tpe_pkg::REP_RST;
            len_reg     <= tpe_pkg::HALF_W'(tpe_pkg::CFG_RST.gap_ticks);
            shift_reg   <= '0;
            bit_cnt_reg <= 4'd0;
            flags_reg   <= 2'b00;
            wave_reg    <= 1'b0;
            play_reg    <= 1'b0;
            end_reg     <= 1'b0;
            byp_a_reg   <= 1'b0;
            byp_b_reg   <= 1'b0;
            res_wp_reg  <= 1'b0;
            res_rp_reg  <= 1'b0;
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            rd_ptr_reg  <= rd_ptr_next;
            kind_reg    <= kind_next;
            stage_reg   <= stage_next;
            half_reg    <= half_next;
            rep_reg     <= rep_next;
            len_reg     <= len_next;
            shift_reg   <= shift_next;
            bit_cnt_reg <= bit_cnt_next;
            flags_reg   <= flags_next;
            wave_reg    <= wave_next;
            play_reg    <= play_next;
            end_reg     <= end_next;
            byp_a_reg   <= byp_a_next;
            byp_b_reg   <= byp_b_next;
            res_wp_reg  <= res_wp_next;
            res_rp_reg  <= res_rp_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            byp_data_reg <= slot.cmd.entry;
        end
        if (fire)
        begin
            res_q_reg[res_wp_reg] <= res;
        end
    end

`ifndef SYNTHESIS
    a_end_not_playing: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg |-> !play_reg)
        else $error("tape ended while still playing");

    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= 4'd8)
        else $error("bit counter out of range");

    a_rewind_loads_pilot: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (slot.cmd.op == tpe_pkg::FUNC_REWIND)) |=>
        ((stage_reg == STG_SYNC1) && (rd_ptr_reg == '0) && !play_reg && !end_reg))
        else $error("rewind did not restart at the first block");

    a_res_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt_reg == 2'd2) |-> !fire || pop_acc)
        else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/tape_pulse_encoder.sv
// Top level of the cassette EAR pulse encoder.
//
// Input channel: a queue-like port. A transaction (item) is taken at a rising
// edge with push high and full low. func selects tick, byte write, rewind or
// play toggle; every transaction yields exactly one result.
// Result channel: result is valid while empty is low and is taken with pop.
// Configuration: cfg_valid/cfg_ready write cfg_data into register cfg_index;
// cfg_ready is always high. Write only while no transaction is in flight.
// Throughput: one transaction per cycle, sustained while the result queue
// has room. The sequencer updates all pulse counters at once and reads the
// tape store through a RAM whose read address follows the next read pointer,
// so no item waits on it. A taken transaction passes the command queue, then
// the result queue, before its result is on the ports.
// Stall: the result queue holds two results; when it is full the sequencer
// stops, the two-entry command queue fills and full rises.
// Reset: queues empty, tape stopped, pilot of the first block next,
// configuration at its defaults. The tape store is not cleared; write it
// before playing. TAPE_DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module tape_pulse_encoder #(
    parameter int TAPE_DEPTH = tpe_pkg::TAPE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire tpe_pkg::in_t                     item,
    input  wire logic                             pop,
    output logic                                  empty,
    output tpe_pkg::out_t                         result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tpe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tpe_pkg::cmd_slot_t slot;
    logic               take;

    // Front end: accept and decode
    tpe_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .slot  (slot),
        .take  (take)
    );

    // Back end: sequencer, store and results
    tpe_back #(
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .slot      (slot),
        .take      (take),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire
